### rtl/prt_pkg.sv
// Package for the point rigid transform block: field widths, derived
// arithmetic widths, register indexes and shared types.
// No dependencies; used by point_rigid_transform, prt_checker and the testbench.
package prt_pkg;

    // Field widths
    localparam int COORD_BITS     = 32;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_BITS      = 16;
    localparam int SHIFT_BITS     = 32;
    localparam int INTENS_BITS    = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Arithmetic widths: q*v, q x v, q*(q x v), accumulator, rounded rotation, sum
    localparam int PROD1_BITS = QUAT_BITS + COORD_BITS;
    localparam int CROSS_BITS = PROD1_BITS + 1;
    localparam int PROD2_BITS = QUAT_BITS + CROSS_BITS;
    localparam int ACC_MIN    = 2 * QUAT_FRAC_BITS + 1;
    localparam int ACC_BITS   = (PROD2_BITS + 4 > ACC_MIN) ? PROD2_BITS + 4 : ACC_MIN;
    localparam int ROT_RAW    = ACC_BITS - 2 * QUAT_FRAC_BITS;
    localparam int ROT_BITS   = (ROT_RAW > COORD_BITS) ? ROT_RAW : COORD_BITS + 1;
    localparam int SUM_BASE   = (ROT_BITS > SHIFT_BITS) ? ROT_BITS : SHIFT_BITS;
    localparam int SUM_BITS   = SUM_BASE + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [QUAT_BITS-1:0]  quat_t;
    typedef logic signed [SHIFT_BITS-1:0] shift_t;
    typedef logic        [INTENS_BITS-1:0] intens_t;
    typedef logic signed [PROD1_BITS-1:0] prod1_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;
    typedef logic signed [PROD2_BITS-1:0] prod2_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic signed [ROT_BITS-1:0]   rot_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // Rounding constant: one half at the accumulator's binary point
    localparam acc_t ROUND_HALF = acc_t'(1) <<< (2 * QUAT_FRAC_BITS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_reg_t;

    localparam quat_t QUAT_ONE = quat_t'(1) <<< QUAT_FRAC_BITS;

    // Bounds of the coordinate range
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // One transformed point as held in the output and skid registers
    typedef struct packed {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        intens_t intensity;
        logic    saturated;
    } result_t;

endpackage

### rtl/point_rigid_transform.sv
// Point rigid transform: quaternion rotation plus translation of lidar points.
// Depends on prt_pkg for widths, register indexes and the result type.
//
// Usage
//   Input channel s_*: one point (x, y, z, intensity) per transaction.
//   Result channel m_*: the rotated and translated point, the intensity
//   copied through and a flag set when any coordinate was clipped.
//   Configuration: cfg_wen writes cfg_wdata to the register cfg_index
//   (quaternion w, x, y, z in Q1.14, then shift x, y, z); unknown indexes
//   are ignored. Write only while no point is in flight.
// Timing
//   An accepted point passes through four pipeline registers (products,
//   cross product, second products, rounding) and then the output
//   register, where the translation and saturation are applied.
//   Throughput is one point per cycle while the skid register is empty,
//   as every stage takes a new point each cycle unless the pipeline holds.
// Reset and stall
//   Reset empties the pipeline and loads the identity transform.
//   When the receiver stalls, one point lands in a skid register and
//   s_ready drops on the next cycle; the whole pipeline then holds until
//   the skid register drains. No point is lost or repeated.
module point_rigid_transform (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration port
    input  logic                                 cfg_wen,
    input  logic [prt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [prt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  prt_pkg::coord_t                      s_point_x,
    input  prt_pkg::coord_t                      s_point_y,
    input  prt_pkg::coord_t                      s_point_z,
    input  prt_pkg::intens_t                     s_intensity,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output prt_pkg::coord_t                      m_out_x,
    output prt_pkg::coord_t                      m_out_y,
    output prt_pkg::coord_t                      m_out_z,
    output prt_pkg::intens_t                     m_out_intensity,
    output logic                                 m_saturated
);

    // Configuration registers
    prt_pkg::quat_t  quat_w_reg;
    prt_pkg::quat_t  quat_v_reg [3];
    prt_pkg::shift_t shift_reg  [3];

    // Pipeline registers
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    prt_pkg::prod1_t  s1_prod_reg [6];
    prt_pkg::cross_t  s2_cross_reg [3];
    prt_pkg::prod2_t  s3_prod_reg [6];
    prt_pkg::prod2_t  s3_wc_reg [3];
    prt_pkg::rot_t    s4_rot_reg [3];
    prt_pkg::coord_t  s1_v_reg [3], s2_v_reg [3], s3_v_reg [3], s4_v_reg [3];
    prt_pkg::intens_t s1_int_reg, s2_int_reg, s3_int_reg, s4_int_reg;

    // Output and skid registers
    logic             out_valid_reg, skid_full_reg;
    prt_pkg::result_t out_reg, skid_reg;

    logic             adv;
    prt_pkg::coord_t  in_v [3];
    prt_pkg::prod1_t  s1_prod_next [6];
    prt_pkg::cross_t  s2_cross_next [3];
    prt_pkg::prod2_t  s3_prod_next [6];
    prt_pkg::prod2_t  s3_wc_next [3];
    prt_pkg::rot_t    s4_rot_next [3];
    prt_pkg::coord_t  res_coord [3];
    logic      [2:0]  res_clip;
    prt_pkg::result_t res;

    // Pipeline moves whenever the skid register is free
    assign adv     = !skid_full_reg;
    assign s_ready = adv;

    assign in_v[0] = s_point_x;
    assign in_v[1] = s_point_y;
    assign in_v[2] = s_point_z;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg <= prt_pkg::QUAT_ONE;
            for (int i = 0; i < 3; i++) begin
                quat_v_reg[i] <= '0;
                shift_reg[i]  <= '0;
            end
        end else if (cfg_wen) begin
            case (prt_pkg::cfg_reg_t'(cfg_index))
                prt_pkg::REG_QUAT_W:  quat_w_reg    <= prt_pkg::quat_t'(cfg_wdata[prt_pkg::QUAT_BITS-1:0]);
                prt_pkg::REG_QUAT_X:  quat_v_reg[0] <= prt_pkg::quat_t'(cfg_wdata[prt_pkg::QUAT_BITS-1:0]);
                prt_pkg::REG_QUAT_Y:  quat_v_reg[1] <= prt_pkg::quat_t'(cfg_wdata[prt_pkg::QUAT_BITS-1:0]);
                prt_pkg::REG_QUAT_Z:  quat_v_reg[2] <= prt_pkg::quat_t'(cfg_wdata[prt_pkg::QUAT_BITS-1:0]);
                prt_pkg::REG_SHIFT_X: shift_reg[0]  <= prt_pkg::shift_t'(cfg_wdata[prt_pkg::SHIFT_BITS-1:0]);
                prt_pkg::REG_SHIFT_Y: shift_reg[1]  <= prt_pkg::shift_t'(cfg_wdata[prt_pkg::SHIFT_BITS-1:0]);
                prt_pkg::REG_SHIFT_Z: shift_reg[2]  <= prt_pkg::shift_t'(cfg_wdata[prt_pkg::SHIFT_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // Stage 1: products of q and v for the first cross product
    always_comb begin
        s1_prod_next[0] = prt_pkg::prod1_t'(quat_v_reg[1]) * prt_pkg::prod1_t'(in_v[2]);
        s1_prod_next[1] = prt_pkg::prod1_t'(quat_v_reg[2]) * prt_pkg::prod1_t'(in_v[1]);
        s1_prod_next[2] = prt_pkg::prod1_t'(quat_v_reg[2]) * prt_pkg::prod1_t'(in_v[0]);
        s1_prod_next[3] = prt_pkg::prod1_t'(quat_v_reg[0]) * prt_pkg::prod1_t'(in_v[2]);
        s1_prod_next[4] = prt_pkg::prod1_t'(quat_v_reg[0]) * prt_pkg::prod1_t'(in_v[1]);
        s1_prod_next[5] = prt_pkg::prod1_t'(quat_v_reg[1]) * prt_pkg::prod1_t'(in_v[0]);
    end

    // Stage 2: c = q x v
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_cross_next[i] = prt_pkg::cross_t'(s1_prod_reg[2*i])
                             - prt_pkg::cross_t'(s1_prod_reg[2*i+1]);
        end
    end

    // Stage 3: products for q x c and w * c
    always_comb begin
        s3_prod_next[0] = prt_pkg::prod2_t'(quat_v_reg[1]) * prt_pkg::prod2_t'(s2_cross_reg[2]);
        s3_prod_next[1] = prt_pkg::prod2_t'(quat_v_reg[2]) * prt_pkg::prod2_t'(s2_cross_reg[1]);
        s3_prod_next[2] = prt_pkg::prod2_t'(quat_v_reg[2]) * prt_pkg::prod2_t'(s2_cross_reg[0]);
        s3_prod_next[3] = prt_pkg::prod2_t'(quat_v_reg[0]) * prt_pkg::prod2_t'(s2_cross_reg[2]);
        s3_prod_next[4] = prt_pkg::prod2_t'(quat_v_reg[0]) * prt_pkg::prod2_t'(s2_cross_reg[1]);
        s3_prod_next[5] = prt_pkg::prod2_t'(quat_v_reg[1]) * prt_pkg::prod2_t'(s2_cross_reg[0]);
        for (int i = 0; i < 3; i++) begin
            s3_wc_next[i] = prt_pkg::prod2_t'(quat_w_reg) * prt_pkg::prod2_t'(s2_cross_reg[i]);
        end
    end

    // Stage 4: sum, double, round half up and drop the fraction
    always_comb begin
        prt_pkg::acc_t acc;
        prt_pkg::acc_t shifted;
        for (int i = 0; i < 3; i++) begin
            acc = prt_pkg::acc_t'(s3_wc_reg[i]) + prt_pkg::acc_t'(s3_prod_reg[2*i])
                - prt_pkg::acc_t'(s3_prod_reg[2*i+1]);
            acc = (acc <<< 1) + prt_pkg::ROUND_HALF;
            shifted = acc >>> (2 * prt_pkg::QUAT_FRAC_BITS);
            s4_rot_next[i] = shifted[prt_pkg::ROT_BITS-1:0];
        end
    end

    // Stage 5: add point and translation, clip to the coordinate range
    always_comb begin
        prt_pkg::sum_t sum;
        logic          ovf;
        for (int i = 0; i < 3; i++) begin
            sum = prt_pkg::sum_t'(s4_rot_reg[i]) + prt_pkg::sum_t'(s4_v_reg[i])
                + prt_pkg::sum_t'(shift_reg[i]);
            ovf = (sum[prt_pkg::SUM_BITS-1:prt_pkg::COORD_BITS-1] != '0)
               && (sum[prt_pkg::SUM_BITS-1:prt_pkg::COORD_BITS-1] != '1);
            res_clip[i] = ovf;
            if (!ovf) begin
                res_coord[i] = sum[prt_pkg::COORD_BITS-1:0];
            end else if (sum[prt_pkg::SUM_BITS-1]) begin
                res_coord[i] = prt_pkg::COORD_MIN;
            end else begin
                res_coord[i] = prt_pkg::COORD_MAX;
            end
        end
        res.x         = res_coord[0];
        res.y         = res_coord[1];
        res.z         = res_coord[2];
        res.intensity = s4_int_reg;
        res.saturated = |res_clip;
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_prod_reg  <= s1_prod_next;
            s2_cross_reg <= s2_cross_next;
            s3_prod_reg  <= s3_prod_next;
            s3_wc_reg    <= s3_wc_next;
            s4_rot_reg   <= s4_rot_next;
            s1_v_reg     <= in_v;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            s4_v_reg     <= s3_v_reg;
            s1_int_reg   <= s_intensity;
            s2_int_reg   <= s1_int_reg;
            s3_int_reg   <= s2_int_reg;
            s4_int_reg   <= s3_int_reg;
        end
    end

    // Output register with skid: catch one result while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= s4_valid_reg;
        end else if (s4_valid_reg) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_x         = out_reg.x;
    assign m_out_y         = out_reg.y;
    assign m_out_z         = out_reg.z;
    assign m_out_intensity = out_reg.intensity;
    assign m_saturated     = out_reg.saturated;

endmodule

### rtl/prt_checker.sv
// Port-level checks for point_rigid_transform, attached by bind.
// Depends on prt_pkg for the coordinate bounds and types.
module prt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input prt_pkg::coord_t   m_out_x,
    input prt_pkg::coord_t   m_out_y,
    input prt_pkg::coord_t   m_out_z,
    input logic              m_saturated
);

    // A stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input back-pressure only while a result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // Back-pressure starts only after a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without receiver stall");

    // A clipped result has a coordinate at a bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_out_x == prt_pkg::COORD_MAX) || (m_out_x == prt_pkg::COORD_MIN) ||
            (m_out_y == prt_pkg::COORD_MAX) || (m_out_y == prt_pkg::COORD_MIN) ||
            (m_out_z == prt_pkg::COORD_MAX) || (m_out_z == prt_pkg::COORD_MIN))
        else $error("saturation flag without clipped coordinate");

endmodule

bind point_rigid_transform prt_checker u_prt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_x     (m_out_x),
    .m_out_y     (m_out_y),
    .m_out_z     (m_out_z),
    .m_saturated (m_saturated)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_rigid_transform: quaternion rotation,
// translation, rounding and saturation of lidar points.
// Depends on prt_pkg and the point_rigid_transform RTL.

import prt_pkg::*;

typedef logic signed [127:0] wide_t;

// Predicts each transformed point and checks results in order of arrival
class point_transform_check;
    localparam int    FRAC2    = 2 * QUAT_FRAC_BITS;
    localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC2 - 1);

    quat_t   quat_w, quat_x, quat_y, quat_z;
    shift_t  shift_x, shift_y, shift_z;
    result_t pending_points[$];
    int      mismatch_count;
    int      points_checked;

    function new();
        quat_w = QUAT_ONE;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        shift_x = '0;
        shift_y = '0;
        shift_z = '0;
        mismatch_count = 0;
        points_checked = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void write_reg(logic [CFG_INDEX_BITS-1:0] index,
                            logic [CFG_DATA_BITS-1:0] data);
        case (index)
            REG_QUAT_W:  quat_w  = quat_t'(data);
            REG_QUAT_X:  quat_x  = quat_t'(data);
            REG_QUAT_Y:  quat_y  = quat_t'(data);
            REG_QUAT_Z:  quat_z  = quat_t'(data);
            REG_SHIFT_X: shift_x = shift_t'(data);
            REG_SHIFT_Y: shift_y = shift_t'(data);
            REG_SHIFT_Z: shift_z = shift_t'(data);
            default: ;
        endcase
    endfunction

    // Exact rotation v + 2w(q x v) + 2q x (q x v), one rounding, then shift
    function result_t rotate_translate(coord_t px, coord_t py, coord_t pz,
                                       intens_t level);
        wide_t   qv [3];
        wide_t   pv [3];
        wide_t   cv [3];
        wide_t   dv [3];
        wide_t   tv [3];
        wide_t   w, acc, hi_lim, lo_lim;
        coord_t  res [3];
        logic    clipped;
        result_t r;
        w = quat_w;
        qv[0] = quat_x;
        qv[1] = quat_y;
        qv[2] = quat_z;
        pv[0] = px;
        pv[1] = py;
        pv[2] = pz;
        tv[0] = shift_x;
        tv[1] = shift_y;
        tv[2] = shift_z;
        hi_lim = COORD_MAX;
        lo_lim = COORD_MIN;
        clipped = 1'b0;
        cv[0] = qv[1] * pv[2] - qv[2] * pv[1];
        cv[1] = qv[2] * pv[0] - qv[0] * pv[2];
        cv[2] = qv[0] * pv[1] - qv[1] * pv[0];
        dv[0] = qv[1] * cv[2] - qv[2] * cv[1];
        dv[1] = qv[2] * cv[0] - qv[0] * cv[2];
        dv[2] = qv[0] * cv[1] - qv[1] * cv[0];
        for (int i = 0; i < 3; i++) begin
            acc = (w * cv[i] + dv[i]) <<< 1;
            // round half towards plus infinity
            acc = ((acc + HALF_LSB) >>> FRAC2) + pv[i] + tv[i];
            if (acc > hi_lim) begin
                acc = hi_lim;
                clipped = 1'b1;
            end else if (acc < lo_lim) begin
                acc = lo_lim;
                clipped = 1'b1;
            end
            res[i] = coord_t'(acc);
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.intensity = level;
        r.saturated = clipped;
        return r;
    endfunction

    function void report(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // Queue the expected result at the tail
    function void note_point(coord_t px, coord_t py, coord_t pz, intens_t level);
        pending_points.insert(pending_points.size(),
                              rotate_translate(px, py, pz, level));
    endfunction

    function void check_point(coord_t gx, coord_t gy, coord_t gz, intens_t gi,
                              logic gs);
        result_t want;
        if (pending_points.size() == 0) begin
            report($sformatf("result (%0d, %0d, %0d) with no point outstanding",
                             gx, gy, gz));
            return;
        end
        want = pending_points.pop_front();
        if (want.x !== gx)
            report($sformatf("point %0d x: expected %0d, got %0d",
                             points_checked, want.x, gx));
        if (want.y !== gy)
            report($sformatf("point %0d y: expected %0d, got %0d",
                             points_checked, want.y, gy));
        if (want.z !== gz)
            report($sformatf("point %0d z: expected %0d, got %0d",
                             points_checked, want.z, gz));
        if (want.intensity !== gi)
            report($sformatf("point %0d intensity: expected %0d, got %0d",
                             points_checked, want.intensity, gi));
        if (want.saturated !== gs)
            report($sformatf("point %0d saturated: expected %0b, got %0b",
                             points_checked, want.saturated, gs));
        points_checked++;
    endfunction

    function int pending();
        return pending_points.size();
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 62;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;
    localparam shift_t SHIFT_HI  = {1'b0, {(SHIFT_BITS-1){1'b1}}};
    localparam shift_t SHIFT_LO  = {1'b1, {(SHIFT_BITS-1){1'b0}}};
    localparam quat_t  QUAT_HI   = {1'b0, {(QUAT_BITS-1){1'b1}}};
    localparam quat_t  QUAT_LO   = {1'b1, {(QUAT_BITS-1){1'b0}}};
    localparam quat_t  QUAT_HALF = QUAT_ONE >>> 1;
    localparam quat_t  QUAT_COS45 = 16'sd11585;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wen;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    coord_t                    s_point_x;
    coord_t                    s_point_y;
    coord_t                    s_point_z;
    intens_t                   s_intensity;
    logic                      m_valid;
    logic                      m_ready;
    coord_t                    m_out_x;
    coord_t                    m_out_y;
    coord_t                    m_out_z;
    intens_t                   m_out_intensity;
    logic                      m_saturated;

    point_transform_check xform;
    bit                   gaps_on;
    int                   quiet_cycles;

    point_rigid_transform u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_point_z       (s_point_z),
        .s_intensity     (s_intensity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_out_intensity (m_out_intensity),
        .m_saturated     (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones; none while gaps are switched off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Lidar-scale values half of the time, full range and extremes otherwise
    function automatic coord_t pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return coord_t'(int'($urandom_range(0, 400000)) - 200000);
        if (r < 85)
            return coord_t'($urandom);
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'(1);
        endcase
    endfunction

    function automatic quat_t pick_quat_in_range();
        return quat_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Sample both channels and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                xform.note_point(s_point_x, s_point_y, s_point_z, s_intensity);
            if (m_valid && m_ready)
                xform.check_point(m_out_x, m_out_y, m_out_z, m_out_intensity,
                                  m_saturated);
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall at random between ready cycles
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = pick_gap();
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
        end
    end

    // Offer one point after a random gap and hold it until accepted
    task automatic send_point(coord_t px, coord_t py, coord_t pz, intens_t level);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_point_x   <= px;
        s_point_y   <= py;
        s_point_z   <= pz;
        s_intensity <= level;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (xform.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index,
                             logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        xform.write_reg(index, data);
    endtask

    // Load all seven registers; junk in the unused upper bits of the quaternion
    task automatic load_transform(quat_t w, quat_t x, quat_t y, quat_t z,
                                  shift_t sx, shift_t sy, shift_t sz);
        write_reg(REG_QUAT_W, {16'($urandom), w});
        write_reg(REG_QUAT_X, {16'($urandom), x});
        write_reg(REG_QUAT_Y, {16'($urandom), y});
        write_reg(REG_QUAT_Z, {16'($urandom), z});
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_SHIFT_Z, sz);
    endtask

    task automatic randomize_transform(int phase);
        quat_t  q [4];
        shift_t t [3];
        for (int i = 0; i < 4; i++)
            q[i] = pick_quat_in_range();
        for (int i = 0; i < 3; i++)
            t[i] = shift_t'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
        case (phase % 4)
            1: begin
                // any register value, any translation
                for (int i = 0; i < 4; i++)
                    q[i] = quat_t'($urandom);
                for (int i = 0; i < 3; i++)
                    t[i] = shift_t'($urandom);
            end
            2: begin
                // close to the identity, as a real pose would be
                q[0] = QUAT_ONE - quat_t'($urandom_range(0, 600));
                for (int i = 1; i < 4; i++)
                    q[i] = quat_t'(int'($urandom_range(0, 4000)) - 2000);
            end
            3: begin
                // translations at the ends of the range
                for (int i = 0; i < 3; i++)
                    case ($urandom_range(0, 2))
                        0: t[i] = SHIFT_HI;
                        1: t[i] = SHIFT_LO;
                        default: t[i] = shift_t'($urandom);
                    endcase
            end
            default: ;
        endcase
        load_transform(q[0], q[1], q[2], q[3], t[0], t[1], t[2]);
        if ($urandom_range(0, 1))
            write_reg(REG_NONE, $urandom);
    endtask

    initial begin
        xform        = new();
        gaps_on      = 1'b1;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = REG_QUAT_W;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_point_x    = '0;
        s_point_y    = '0;
        s_point_z    = '0;
        s_intensity  = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Identity after reset: extremes pass through untouched
        send_point(0, 0, 0, 16'h0000);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000);
        send_point(COORD_MAX, COORD_MIN, 0, 16'h8000);
        send_point(1, -1, 12345, 16'h5555);
        drain();

        // Translation alone pushes coordinates past either bound
        load_transform(QUAT_ONE, 0, 0, 0, SHIFT_HI, SHIFT_LO, 0);
        send_point(1, -1, 5, 16'hAAAA);
        send_point(COORD_MIN, COORD_MAX, 0, 16'h0001);
        send_point(0, 0, COORD_MIN, 16'h7FFF);
        drain();

        // Half a unit of rotation offset: halves round towards plus infinity
        load_transform(0, 0, 0, QUAT_HALF, 0, 0, 0);
        write_reg(REG_NONE, $urandom);
        send_point(1, 0, 0, 16'h0102);
        send_point(-1, 0, 0, 16'h0304);
        send_point(0, 1, 0, 16'h0506);
        send_point(0, -1, 0, 16'h0708);
        drain();

        // Far from unit length: rotation alone overflows the range
        load_transform(QUAT_LO, QUAT_LO, QUAT_LO, QUAT_LO, 0, 0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'h1234);
        send_point(COORD_MIN, 0, COORD_MAX, 16'h4321);
        send_point(COORD_MAX, COORD_MIN, 1, 16'hFFFE);
        drain();
        load_transform(QUAT_HI, QUAT_HI, QUAT_HI, QUAT_HI, SHIFT_LO, SHIFT_HI, 0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h00FF);
        drain();

        // Quarter turn about z with a small offset
        load_transform(QUAT_COS45, 0, 0, QUAT_COS45, 100, -100, 0);
        send_point(1000, 0, 0, 16'h0010);
        send_point(0, 1000, 0, 16'h0020);
        send_point(-7, 3, 2, 16'h0030);
        drain();

        // Random transforms; every third phase runs without gaps on either side
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            gaps_on = (phase % 3 != 1);
            randomize_transform(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_point(pick_coord(), pick_coord(), pick_coord(), intens_t'($urandom));
            end
            drain();
        end
        gaps_on = 1'b1;

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (xform.mismatch_count == 0 && xform.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### point_rigid_transform.f
rtl/prt_pkg.sv
rtl/point_rigid_transform.sv
rtl/prt_checker.sv
tb/testbench.sv
